FILE: rtl/core/spindle_speed_snap_top_macros.svh
// Assertion macros for the spindle speed table.
// The checks sample on clk and are written inside modules that have clk and rst.
`ifndef SPINDLE_SPEED_SNAP_TOP_MACROS_SVH
`define SPINDLE_SPEED_SNAP_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check that is switched off while reset is high.
`define SSNAP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spindle_speed_snap: check failed");

// Check that also holds while reset is high.
`define SSNAP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("spindle_speed_snap: check failed");

`else

`define SSNAP_ASSERT(label, prop)
`define SSNAP_ASSERT_ALWAYS(label, prop)

`endif

`endif

FILE: rtl/core/ssnap_pkg.sv
`default_nettype none

package ssnap_pkg;

  // Width of every rpm value.
  localparam int SPEED_W = 20;

  // Item modes.
  localparam logic [1:0] MODE_NORM      = 2'd0;
  localparam logic [1:0] MODE_ADD_RANGE = 2'd1;
  localparam logic [1:0] MODE_ADD_DISC  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_TOL  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Register byte address of the tolerance register.
  localparam logic [1:0] REG_TOLERANCE = 2'd0;

  // Control from the sequencer to the nearest-entry unit.
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

  // Running search result.
  typedef struct packed {
    logic                 found;
    logic                 contained;
    logic [SPEED_W-1:0]   gap;
    logic [SPEED_W-1:0]   target;
  } best_t;

endpackage

`default_nettype wire

FILE: rtl/core/ssnap_best.sv
`default_nettype none

// Nearest-entry tracker: takes one table entry per sample and keeps the
// closest boundary seen so far, with ties going to the lower target; it also flags an entry that contains the speed.
module ssnap_best (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ssnap_pkg::scan_ctl_t          ctl,
  input  wire logic [ssnap_pkg::SPEED_W-1:0] speed,
  input  wire logic [ssnap_pkg::SPEED_W-1:0] entry_low,
  input  wire logic [ssnap_pkg::SPEED_W-1:0] entry_high,
  output ssnap_pkg::best_t                   best
);

  logic                          below;
  logic                          above;
  logic [ssnap_pkg::SPEED_W-1:0] gap;
  logic [ssnap_pkg::SPEED_W-1:0] target;
  logic                          better;

  // Distance and target of the current entry.
  always_comb begin
    below  = speed < entry_low;
    above  = speed > entry_high;
    gap    = below ? (entry_low - speed) : (speed - entry_high);
    target = below ? entry_low : entry_high;
    better = !best.found || (gap < best.gap) ||
             ((gap == best.gap) && (target < best.target));
  end

  // Flags carry reset; distance and target are only read once found is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      best.found     <= 1'b0;
      best.contained <= 1'b0;
    end else if (ctl.clear) begin
      best.found     <= 1'b0;
      best.contained <= 1'b0;
    end else if (ctl.sample) begin
      if (!below && !above) begin
        best.contained <= 1'b1;
      end else if (better) begin
        best.found <= 1'b1;
      end
    end
    if (ctl.sample && (below || above) && better) begin
      best.gap    <= gap;
      best.target <= target;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/spindle_speed_snap_top.sv
// Add items, unknown modes and normalise on an empty table go from idle to S_FIN,
// then the result is loaded into the output register once that register is free. Other
// normalise items read the stored entries one by one in S_SCAN, then pass S_DRAIN and S_FIN.
// One item is in work at a time; the next is taken once the result is in the output register.
// Reset (rst, synchronous) empties the table and clears tolerance and out_valid.
`default_nettype none
`include "spindle_speed_snap_top_macros.svh"

module spindle_speed_snap_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input item channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    mode,
  input  wire logic [ssnap_pkg::SPEED_W-1:0] speed,
  input  wire logic [ssnap_pkg::SPEED_W-1:0] range_top,
  // Result item channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ssnap_pkg::SPEED_W-1:0]      snapped_speed,
  output logic [1:0]                         status,
  // Register port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [1:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int SW = ssnap_pkg::SPEED_W;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [AW-1:0] rd_idx;
  logic          rd_vld;
  logic [SW-1:0] tolerance;
  logic [1:0]    item_mode;
  logic [SW-1:0] item_speed;
  logic [1:0]    add_status;

  logic            accept;
  logic            full;
  logic            mem_we;
  logic [2*SW-1:0] mem_wdata;
  logic            rd_en;
  logic [2*SW-1:0] rd_data;
  logic            out_load;
  logic [SW-1:0]   res_speed;
  logic [1:0]      res_status;

  ssnap_pkg::scan_ctl_t ctl;
  ssnap_pkg::best_t     best;

  // Table storage: low in the lower half, high in the upper half.
  logic [2*SW-1:0] entry_mem [TABLE_DEPTH];

  // Register port: tolerance is the only register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (psel && penable && pwrite && (paddr == ssnap_pkg::REG_TOLERANCE)) begin
      tolerance <= pwdata[SW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ssnap_pkg::REG_TOLERANCE) begin
      prdata = {{(32-SW){1'b0}}, tolerance};
    end
  end

  // Handshake and table writes. Writes happen only while idle and reads only
  // during the scan, so an entry is never read and written at once.
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (count == CW'(TABLE_DEPTH));
  assign mem_we    = accept && !full &&
                     ((mode == ssnap_pkg::MODE_ADD_RANGE) || (mode == ssnap_pkg::MODE_ADD_DISC));
  assign mem_wdata = (mode == ssnap_pkg::MODE_ADD_RANGE) ? {range_top, speed} : {speed, speed};
  assign rd_en     = (state == S_SCAN);
  assign out_load  = (state == S_FIN) && (!out_valid || !out_stall);

  assign ctl.clear  = accept;
  assign ctl.sample = rd_vld;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[count[AW-1:0]] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= entry_mem[rd_idx];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_idx <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (mem_we) begin
        count <= count + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          rd_idx <= '0;
          if (accept) begin
            if ((mode == ssnap_pkg::MODE_NORM) && (count != '0)) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          rd_idx <= rd_idx + AW'(1);
          if (CW'(rd_idx) == (count - CW'(1))) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item fields and the status of an add, captured at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode  <= mode;
      item_speed <= speed;
      if (((mode == ssnap_pkg::MODE_ADD_RANGE) || (mode == ssnap_pkg::MODE_ADD_DISC)) && full) begin
        add_status <= ssnap_pkg::ST_FULL;
      end else begin
        add_status <= ssnap_pkg::ST_OK;
      end
    end
  end

  ssnap_best u_best (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .speed      (item_speed),
    .entry_low  (rd_data[SW-1:0]),
    .entry_high (rd_data[2*SW-1:SW]),
    .best       (best)
  );

  // Final result of the item.
  always_comb begin
    res_speed  = '0;
    res_status = add_status;
    if (item_mode == ssnap_pkg::MODE_NORM) begin
      if (!best.found || best.contained) begin
        res_speed  = item_speed;
        res_status = ssnap_pkg::ST_OK;
      end else if (best.gap > tolerance) begin
        res_status = ssnap_pkg::ST_TOL;
      end else begin
        res_speed  = best.target;
        res_status = ssnap_pkg::ST_OK;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      snapped_speed <= res_speed;
      status        <= res_status;
    end
  end

  // The fill count never passes the table size.
  `SSNAP_ASSERT(a_count_bound, count <= CW'(TABLE_DEPTH))
  // A table write only happens with a free slot.
  `SSNAP_ASSERT(a_write_free, mem_we |-> (count < CW'(TABLE_DEPTH)))
  // Every entry read has been folded in before the result is formed.
  `SSNAP_ASSERT(a_fin_drained, (state == S_FIN) |-> !rd_vld)
  // A full table report carries no speed.
  `SSNAP_ASSERT_ALWAYS(a_full_zero,
    (out_valid && (status == ssnap_pkg::ST_FULL)) |-> (snapped_speed == '0))

endmodule

`default_nettype wire
